// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants for the bilinear texture sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bts_pkg;

	localparam int DEF_MAX_TEX_WIDTH  = 64;
	localparam int DEF_MAX_TEX_HEIGHT = 64;

	localparam int S_TDATA_W = 120;
	localparam int M_TDATA_W = 32;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	// register indexes
	localparam logic [2:0] REG_WIDTH     = 3'd0;
	localparam logic [2:0] REG_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_EDGE_MODE = 3'd2;
	localparam logic [2:0] REG_LINEAR    = 3'd3;
	localparam logic [2:0] REG_HAS_ALPHA = 3'd4;
	localparam logic [2:0] REG_ALPHA_MOD = 3'd5;

	// opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// edge modes
	localparam logic [1:0] EDGE_CLAMP  = 2'd0;
	localparam logic [1:0] EDGE_MODULO = 2'd1;
	localparam logic [1:0] EDGE_MASK   = 2'd2;

endpackage

// ===== hdl/bts_texel_ram.sv =====
// ----------------------------------------------------------------------------
// bts_texel_ram
// Texel memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bts_texel_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [31:0]   rdata0,
	output logic [31:0]   rdata1
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== hdl/bilinear_texture_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Texel store plus nearest/bilinear sampler with clamp, modulo and mask wrap.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat content
// s_*       in   tuser: opcode; tdata: column, row, texel, pos x, pos y, alpha
// m_*       out  tdata: alpha, red, green, blue
// APB       in   six config registers at 4*index
//
// Eight pipeline stages, one beat per cycle while m_tready is high.
// The depth is set by the two 8-bit halves of the wrap remainder and the
// two multiply stages of the filter. Every stage has its own valid bit and
// loads when it is empty or its successor loads, so bubbles close up and a
// stall at m_tready backs up one stage at a time. Reset clears valid bits
// and loads config defaults; the texel store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bilinear_texture_sampler #(
	parameter int MAX_TEX_WIDTH  = bts_pkg::DEF_MAX_TEX_WIDTH,
	parameter int MAX_TEX_HEIGHT = bts_pkg::DEF_MAX_TEX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [5:0] texel_column, [11:6] texel_row, [43:12] texel_value,
	// [75:44] position_x, [107:76] position_y, [115:108] alpha_in, rest zero
	input  logic [bts_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,  // [0] opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] pixel_alpha, [15:8] pixel_red, [23:16] pixel_green, [31:24] pixel_blue
	output logic [bts_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bts_pkg::PADDR_W-1:0]   paddr,
	input  logic [bts_pkg::PDATA_W-1:0]   pwdata,
	output logic [bts_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import bts_pkg::*;

	localparam int DEPTH = MAX_TEX_WIDTH * MAX_TEX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// ---------------- configuration ----------------
	logic [6:0] width_q, height_q;
	logic [1:0] edge_mode_q;
	logic       linear_q, has_alpha_q, amod_q;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 7'd64;
			height_q    <= 7'd64;
			edge_mode_q <= EDGE_CLAMP;
			linear_q    <= 1'b0;
			has_alpha_q <= 1'b1;
			amod_q      <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_WIDTH:     width_q     <= pwdata[6:0];
				REG_HEIGHT:    height_q    <= pwdata[6:0];
				REG_EDGE_MODE: edge_mode_q <= pwdata[1:0];
				REG_LINEAR:    linear_q    <= pwdata[0];
				REG_HAS_ALPHA: has_alpha_q <= pwdata[0];
				REG_ALPHA_MOD: amod_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH:     prdata = {25'd0, width_q};
			REG_HEIGHT:    prdata = {25'd0, height_q};
			REG_EDGE_MODE: prdata = {30'd0, edge_mode_q};
			REG_LINEAR:    prdata = {31'd0, linear_q};
			REG_HAS_ALPHA: prdata = {31'd0, has_alpha_q};
			REG_ALPHA_MOD: prdata = {31'd0, amod_q};
			default:       prdata = '0;
		endcase
	end

	// effective sizes: zero acts as one, above the store acts as its maximum
	logic [6:0] w_eff, h_eff;
	logic [1:0] mode;

	assign w_eff = (width_q == 7'd0) ? 7'd1 :
		(32'(width_q) > MAX_TEX_WIDTH) ? 7'(MAX_TEX_WIDTH) : width_q;
	assign h_eff = (height_q == 7'd0) ? 7'd1 :
		(32'(height_q) > MAX_TEX_HEIGHT) ? 7'(MAX_TEX_HEIGHT) : height_q;
	assign mode  = (edge_mode_q == EDGE_MASK || edge_mode_q == EDGE_MODULO) ?
		edge_mode_q : EDGE_CLAMP;

	// eight restoring remainder steps, one dividend bit each
	function automatic logic [6:0] rem_steps(input logic [6:0] r_in,
		input logic [7:0] bits, input logic [6:0] sz);
		logic [7:0] t;
		logic [6:0] r;
		r = r_in;
		for (int i = 7; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, sz}) begin
				t = t - {1'b0, sz};
			end
			r = t[6:0];
		end
		return r;
	endfunction

	// first and second tap on one axis: {c1, c0}
	function automatic logic [13:0] axis_pair(input logic signed [15:0] c,
		input logic [6:0] rem, input logic [6:0] sz, input logic [1:0] md);
		logic [6:0] c0, c1, m, r, rp;
		m  = sz - 7'd1;
		r  = (c[15] && rem != 7'd0) ? sz - rem : rem;
		rp = r + 7'd1;
		case (md)
			EDGE_MASK: begin
				c0 = c[6:0] & m;
				c1 = (c[6:0] + 7'd1) & m;
			end
			EDGE_MODULO: begin
				c0 = r;
				c1 = (rp == sz) ? 7'd0 : rp;
			end
			default: begin
				if (c[15]) begin
					c0 = 7'd0;
					c1 = 7'd0;
				end else if (c >= $signed({9'd0, m})) begin
					c0 = m;
					c1 = m;
				end else begin
					c0 = c[6:0];
					c1 = rp == 7'd0 ? c[6:0] + 7'd1 : c[6:0] + 7'd1;
				end
			end
		endcase
		return {c1, c0};
	endfunction

	// ---------------- stage enables ----------------
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7, v8_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic op5_s5;

	assign en8 = !v8_s8 || m_tready;
	assign en7 = !v7_s7 || en8;
	assign en6 = !v6_s6 || en7;
	assign en5 = !v5_s5 || en6;
	assign en4 = !v4_s4 || en5;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0; v2_s2 <= 1'b0; v3_s3 <= 1'b0; v4_s4 <= 1'b0;
			v5_s5 <= 1'b0; v6_s6 <= 1'b0; v7_s7 <= 1'b0; v8_s8 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= s_tvalid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
			// write beats end at the store
			if (en6) v6_s6 <= v5_s5 && op5_s5 == OP_SAMPLE;
			if (en7) v7_s7 <= v6_s6;
			if (en8) v8_s8 <= v7_s7;
		end
	end

	// ---------------- stage 1: unpack, integer part, magnitude ----------------
	logic               op1_s1;
	logic [5:0]         col1_s1, row1_s1;
	logic [31:0]        tex1_s1;
	logic signed [15:0] x1_s1, y1_s1;
	logic [15:0]        ax1_s1, ay1_s1;
	logic [7:0]         fx1_s1, ain1_s1;
	logic [15:0]        fy1_s1;
	logic [15:0]        xi, yi;

	assign xi = s_tdata[75:60];
	assign yi = s_tdata[107:92];

	always_ff @(posedge clk) begin
		if (en1) begin
			op1_s1  <= s_tuser;
			col1_s1 <= s_tdata[5:0];
			row1_s1 <= s_tdata[11:6];
			tex1_s1 <= s_tdata[43:12];
			x1_s1   <= xi;
			y1_s1   <= yi;
			ax1_s1  <= xi[15] ? 16'(~xi + 16'd1) : xi;
			ay1_s1  <= yi[15] ? 16'(~yi + 16'd1) : yi;
			// nearest is bilinear with zero weights
			fx1_s1  <= linear_q ? s_tdata[59:52] : 8'd0;
			fy1_s1  <= linear_q ? s_tdata[91:76] : 16'd0;
			ain1_s1 <= s_tdata[115:108];
		end
	end

	// ---------------- stage 2: remainder, high byte ----------------
	logic               op2_s2;
	logic [5:0]         col2_s2, row2_s2;
	logic [31:0]        tex2_s2;
	logic signed [15:0] x2_s2, y2_s2;
	logic [7:0]         axl2_s2, ayl2_s2, fx2_s2, ain2_s2;
	logic [15:0]        fy2_s2;
	logic [6:0]         rx2_s2, ry2_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			op2_s2  <= op1_s1;
			col2_s2 <= col1_s1;
			row2_s2 <= row1_s1;
			tex2_s2 <= tex1_s1;
			x2_s2   <= x1_s1;
			y2_s2   <= y1_s1;
			axl2_s2 <= ax1_s1[7:0];
			ayl2_s2 <= ay1_s1[7:0];
			rx2_s2  <= rem_steps(7'd0, ax1_s1[15:8], w_eff);
			ry2_s2  <= rem_steps(7'd0, ay1_s1[15:8], h_eff);
			fx2_s2  <= fx1_s1;
			fy2_s2  <= fy1_s1;
			ain2_s2 <= ain1_s1;
		end
	end

	// ---------------- stage 3: remainder, low byte ----------------
	logic               op3_s3;
	logic [5:0]         col3_s3, row3_s3;
	logic [31:0]        tex3_s3;
	logic signed [15:0] x3_s3, y3_s3;
	logic [7:0]         fx3_s3, ain3_s3;
	logic [15:0]        fy3_s3;
	logic [6:0]         rx3_s3, ry3_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			op3_s3  <= op2_s2;
			col3_s3 <= col2_s2;
			row3_s3 <= row2_s2;
			tex3_s3 <= tex2_s2;
			x3_s3   <= x2_s2;
			y3_s3   <= y2_s2;
			rx3_s3  <= rem_steps(rx2_s2, axl2_s2, w_eff);
			ry3_s3  <= rem_steps(ry2_s2, ayl2_s2, h_eff);
			fx3_s3  <= fx2_s2;
			fy3_s3  <= fy2_s2;
			ain3_s3 <= ain2_s2;
		end
	end

	// ---------------- stage 4: tap coordinates and addresses ----------------
	logic          op4_s4;
	logic [5:0]    col4_s4, row4_s4;
	logic [31:0]   tex4_s4;
	logic [7:0]    fx4_s4, ain4_s4;
	logic [15:0]   fy4_s4;
	logic [AW-1:0] a00_s4, a01_s4, a10_s4, a11_s4;
	logic [13:0]   xp, yp;

	assign xp = axis_pair(x3_s3, rx3_s3, w_eff, mode);
	assign yp = axis_pair(y3_s3, ry3_s3, h_eff, mode);

	always_ff @(posedge clk) begin
		if (en4) begin
			op4_s4  <= op3_s3;
			col4_s4 <= col3_s3;
			row4_s4 <= row3_s3;
			tex4_s4 <= tex3_s3;
			a00_s4  <= AW'(AW'(yp[6:0]) * AW'(MAX_TEX_WIDTH) + AW'(xp[6:0]));
			a01_s4  <= AW'(AW'(yp[6:0]) * AW'(MAX_TEX_WIDTH) + AW'(xp[13:7]));
			a10_s4  <= AW'(AW'(yp[13:7]) * AW'(MAX_TEX_WIDTH) + AW'(xp[6:0]));
			a11_s4  <= AW'(AW'(yp[13:7]) * AW'(MAX_TEX_WIDTH) + AW'(xp[13:7]));
			fx4_s4  <= fx3_s3;
			fy4_s4  <= fy3_s3;
			ain4_s4 <= ain3_s3;
		end
	end

	// ---------------- stage 5: texel store ----------------
	// Two copies, one per tap row, each read at two columns. Writes hit both
	// copies as the write beat enters this stage, so later samples see it.
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   p00, p01, p10, p11;
	logic [7:0]    fx5_s5, ain5_s5;
	logic [15:0]   fy5_s5;

	assign we = en5 && v4_s4 && op4_s4 == OP_WRITE &&
		32'(col4_s4) < MAX_TEX_WIDTH && 32'(row4_s4) < MAX_TEX_HEIGHT;
	assign waddr = AW'(AW'(row4_s4) * AW'(MAX_TEX_WIDTH) + AW'(col4_s4));

	bts_texel_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_top (
		.clk(clk), .we(we), .waddr(waddr), .wdata(tex4_s4), .re(en5),
		.raddr0(a00_s4), .raddr1(a01_s4), .rdata0(p00), .rdata1(p01)
	);

	bts_texel_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_bot (
		.clk(clk), .we(we), .waddr(waddr), .wdata(tex4_s4), .re(en5),
		.raddr0(a10_s4), .raddr1(a11_s4), .rdata0(p10), .rdata1(p11)
	);

	always_ff @(posedge clk) begin
		if (en5) begin
			op5_s5  <= op4_s4;
			fx5_s5  <= fx4_s4;
			fy5_s5  <= fy4_s4;
			ain5_s5 <= ain4_s4;
		end
	end

	// ---------------- stage 6: horizontal blend ----------------
	logic [15:0] top6_s6 [4];
	logic [15:0] bot6_s6 [4];
	logic [15:0] fy6_s6;
	logic [7:0]  ain6_s6;
	logic [8:0]  nx;

	assign nx = 9'd256 - {1'b0, fx5_s5};

	always_ff @(posedge clk) begin
		if (en6) begin
			for (int k = 0; k < 4; k++) begin
				top6_s6[k] <= 16'(17'(p00[8*k +: 8]) * 17'(nx) +
					17'(p01[8*k +: 8]) * 17'(fx5_s5));
				bot6_s6[k] <= 16'(17'(p10[8*k +: 8]) * 17'(nx) +
					17'(p11[8*k +: 8]) * 17'(fx5_s5));
			end
			fy6_s6  <= fy5_s5;
			ain6_s6 <= ain5_s5;
		end
	end

	// ---------------- stage 7: vertical blend ----------------
	// channel k: 0 blue, 1 green, 2 red, 3 alpha
	logic [7:0]  ch7_s7 [4];
	logic [7:0]  ain7_s7;
	logic [16:0] ny;
	logic [32:0] vsum [4];

	assign ny = 17'h10000 - {1'b0, fy6_s6};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vsum[k] = 33'(top6_s6[k]) * 33'(ny) + 33'(bot6_s6[k]) * 33'(fy6_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			for (int k = 0; k < 3; k++) begin
				ch7_s7[k] <= vsum[k][31:24];
			end
			ch7_s7[3] <= has_alpha_q ? vsum[3][31:24] : 8'd255;
			ain7_s7   <= ain6_s6;
		end
	end

	// ---------------- stage 8: alpha modulation, output register ----------------
	logic [7:0]  a8_s8, r8_s8, g8_s8, b8_s8;
	logic [15:0] amul;

	assign amul = 16'(ch7_s7[3]) * 16'(ain7_s7);

	always_ff @(posedge clk) begin
		if (en8) begin
			a8_s8 <= !amod_q ? ch7_s7[3] : (has_alpha_q ? amul[15:8] : ain7_s7);
			r8_s8 <= ch7_s7[2];
			g8_s8 <= ch7_s7[1];
			b8_s8 <= ch7_s7[0];
		end
	end

	assign m_tvalid = v8_s8;
	assign m_tdata  = {b8_s8, g8_s8, r8_s8, a8_s8};

endmodule

// ===== hdl/bts_checker.sv =====
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks for the bilinear texture sampler, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [bts_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bts_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [bts_pkg::PADDR_W-1:0]   paddr,
	input logic [bts_pkg::PDATA_W-1:0]   pwdata,
	input logic [bts_pkg::PDATA_W-1:0]   prdata,
	input logic                          pready
);
	import bts_pkg::*;

	logic edge_wr;

	assign edge_wr = psel && penable && pwrite && paddr[4:2] == REG_EDGE_MODE;

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "result changed while stalled")

	// input backs up only when the pipe is full and the output is stalled
	`ASSERT_IMPL(a_back_pressure, clk, arst_n, !s_tready,
		m_tvalid && !m_tready, "input stalled without output stall")

	`ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready, "pready dropped")

	// edge mode reads back what was written
	`ASSERT_NEXT(a_edge_readback, clk, arst_n, edge_wr,
		paddr != $past(paddr) || prdata[1:0] == $past(pwdata[1:0]),
		"edge mode readback mismatch")

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (.*);
